@@ src/ocg_pkg.sv @@
`timescale 1ns / 1ps
package ocg_pkg;

   // default grid geometry
   localparam int DEF_GRID_W     = 512;
   localparam int DEF_GRID_H     = 512;
   localparam int DEF_COUNT_BITS = 8;

   // coordinate width that covers the largest supported grid side
   localparam int CRD_W = 12;

   // register indexes on the csr port
   localparam logic [2:0] REG_CELL_RECIP  = 3'd0;
   localparam logic [2:0] REG_Z_MIN       = 3'd1;
   localparam logic [2:0] REG_Z_MAX       = 3'd2;
   localparam logic [2:0] REG_RANGE       = 3'd3;
   localparam logic [2:0] REG_MIN_POINTS  = 3'd4;
   localparam logic [2:0] REG_DIL_RADIUS  = 3'd5;
   localparam logic [2:0] REG_CLR_RADIUS  = 3'd6;
   localparam logic [2:0] REG_INIT_FREE   = 3'd7;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_POINT = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CLS_FREE    = 2'd0,
      CLS_OCC     = 2'd1,
      CLS_UNKNOWN = 2'd2
   } cls_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_POINT,
      CMD_QUERY
   } cmd_kind_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_INC,
      B_QHIT,
      B_WALK,
      B_WTAIL,
      B_RESP
   } back_state_type;

   // one queued command from front to back
   typedef struct packed {
      cmd_kind_type     kind;
      logic [CRD_W-1:0] cx;
      logic [CRD_W-1:0] cy;
      logic             outside;
      logic             cleared;
   } cmd_type;

   typedef struct packed {
      logic [20:0]        cell_recip;
      logic signed [23:0] z_min;
      logic signed [23:0] z_max;
      logic [22:0]        range_mm;
      logic [7:0]         min_points;
      logic [3:0]         dil_radius;
      logic [4:0]         clr_radius;
      logic               init_free;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

endpackage

@@ src/ocg_queue.sv @@
`timescale 1ns / 1ps
module ocg_queue
   import ocg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   cmd_type       store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/ocg_front.sv @@
`timescale 1ns / 1ps
module ocg_front
   import ocg_pkg::*;
#(
   parameter int GRID_W = DEF_GRID_W,
   parameter int GRID_H = DEF_GRID_H
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  back_stat_type      bstat,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [23:0] req_point_x,
   input  logic signed [23:0] req_point_y,
   input  logic signed [23:0] req_point_z,
   input  logic signed [23:0] req_origin_x,
   input  logic signed [23:0] req_origin_y,
   input  logic signed [23:0] req_robot_x,
   input  logic signed [23:0] req_robot_y,
   input  logic               req_robot_known,
   input  logic [8:0]         req_query_x,
   input  logic [8:0]         req_query_y,
   output logic               push,
   output cmd_type            push_cmd,
   input  logic               q_full
);

   front_state_type state_ff, state_in;

   mode_type           mode_ff;
   logic signed [23:0] px_ff, py_ff, pz_ff;
   logic [8:0]         qx_ff, qy_ff;
   logic signed [24:0] diff_x_ff, diff_y_ff;
   logic signed [46:0] prod_x_ff, prod_y_ff;
   logic signed [47:0] sq_x_ff, sq_y_ff;
   logic [45:0]        sq_r_ff;
   logic signed [23:0] org_x_ff, org_y_ff;
   logic signed [24:0] rob_cx_ff, rob_cy_ff;
   logic               rob_valid_ff;

   logic               accept;
   logic signed [26:0] cell_x, cell_y;
   logic               cell_in_grid;
   logic               z_ok, range_ok;
   logic [47:0]        sq_sum;
   logic               q_outside;
   logic signed [25:0] ex, ey;
   logic signed [5:0]  ex6, ey6;
   logic [11:0]        esq;
   logic signed [25:0] crs;
   logic               e_box, cleared;
   logic               want_push;

   assign req_stall = (state_ff != F_IDLE) || bstat.clearing;
   assign accept    = req_valid && !req_stall;

   // floor of the scaled offset, arithmetic shift
   assign cell_x = prod_x_ff[46:20];
   assign cell_y = prod_y_ff[46:20];
   assign cell_in_grid = !cell_x[26] && !cell_y[26]
                       && (cell_x[25:0] < 26'(GRID_W))
                       && (cell_y[25:0] < 26'(GRID_H));

   // height band and planar range
   assign z_ok     = (pz_ff >= cfg.z_min) && (pz_ff <= cfg.z_max);
   assign sq_sum   = sq_x_ff[47:0] + sq_y_ff[47:0];
   assign range_ok = (cfg.range_mm == '0) || (sq_sum <= 48'(sq_r_ff));

   // query: grid bounds and robot clearing disk
   assign q_outside = (13'(qx_ff) >= 13'(GRID_W)) || (13'(qy_ff) >= 13'(GRID_H));
   assign ex  = $signed({17'b0, qx_ff}) - 26'(rob_cx_ff);
   assign ey  = $signed({17'b0, qy_ff}) - 26'(rob_cy_ff);
   assign crs = $signed({21'b0, cfg.clr_radius});
   assign e_box = (ex >= -crs) && (ex <= crs) && (ey >= -crs) && (ey <= crs);
   assign ex6 = ex[5:0];
   assign ey6 = ey[5:0];
   assign esq = 12'(12'(ex6) * 12'(ex6)) + 12'(12'(ey6) * 12'(ey6));
   assign cleared = rob_valid_ff && (cfg.clr_radius != '0) && e_box
                  && (esq <= 12'(10'(cfg.clr_radius) * 10'(cfg.clr_radius)));

   // command build
   always_comb begin
      push_cmd         = '0;
      push_cmd.kind    = CMD_START;
      want_push        = 1'b0;
      unique case (mode_ff)
         MODE_START: begin
            want_push = 1'b1;
         end
         MODE_POINT: begin
            push_cmd.kind = CMD_POINT;
            push_cmd.cx   = cell_x[CRD_W-1:0];
            push_cmd.cy   = cell_y[CRD_W-1:0];
            want_push     = z_ok && range_ok && cell_in_grid;
         end
         MODE_QUERY: begin
            push_cmd.kind    = CMD_QUERY;
            push_cmd.cx      = CRD_W'(qx_ff);
            push_cmd.cy      = CRD_W'(qy_ff);
            push_cmd.outside = q_outside;
            push_cmd.cleared = cleared;
            want_push        = 1'b1;
         end
         default: begin
            want_push = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!want_push) begin
               state_in = F_IDLE;
            end else if (!q_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         org_x_ff     <= '0;
         org_y_ff     <= '0;
         rob_cx_ff    <= '0;
         rob_cy_ff    <= '0;
         rob_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && mode_type'(req_mode) == MODE_START) begin
            org_x_ff     <= req_origin_x;
            org_y_ff     <= req_origin_y;
            rob_valid_ff <= req_robot_known;
         end
         if (state_ff == F_PUSH && mode_ff == MODE_START) begin
            rob_cx_ff <= cell_x[24:0];
            rob_cy_ff <= cell_y[24:0];
         end
      end
   end

   // item capture and products
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= mode_type'(req_mode);
         px_ff   <= req_point_x;
         py_ff   <= req_point_y;
         pz_ff   <= req_point_z;
         qx_ff   <= req_query_x;
         qy_ff   <= req_query_y;
         if (mode_type'(req_mode) == MODE_START) begin
            diff_x_ff <= 25'(req_robot_x) - 25'(req_origin_x);
            diff_y_ff <= 25'(req_robot_y) - 25'(req_origin_y);
         end else begin
            diff_x_ff <= 25'(req_point_x) - 25'(org_x_ff);
            diff_y_ff <= 25'(req_point_y) - 25'(org_y_ff);
         end
      end
      if (state_ff == F_MUL) begin
         prod_x_ff <= 47'(diff_x_ff) * $signed({26'b0, cfg.cell_recip});
         prod_y_ff <= 47'(diff_y_ff) * $signed({26'b0, cfg.cell_recip});
         sq_x_ff   <= 48'(px_ff) * 48'(px_ff);
         sq_y_ff   <= 48'(py_ff) * 48'(py_ff);
         sq_r_ff   <= 46'(cfg.range_mm) * 46'(cfg.range_mm);
      end
   end

endmodule

@@ src/ocg_back.sv @@
`timescale 1ns / 1ps
module ocg_back
   import ocg_pkg::*;
#(
   parameter int GRID_W     = DEF_GRID_W,
   parameter int GRID_H     = DEF_GRID_H,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   output back_stat_type bstat,
   input  cmd_type       head,
   input  logic          q_empty,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_cell_class,
   output logic [7:0]    rsp_hit_count
);

   localparam int DEPTH  = GRID_W * GRID_H;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIN_W  = 2 * CRD_W;

   back_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [ADDR_W-1:0]     inc_addr_ff, inc_addr_in;
   cmd_type               cmd_ff, cmd_in;
   logic signed [4:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic                  pend_ff, pend_in;
   logic                  occ_ff, occ_in;
   logic [COUNT_BITS-1:0] hits_ff, hits_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cls_type               cls_ff, cls_in;
   logic [7:0]            hit8_ff, hit8_in;

   logic [LIN_W-1:0]      head_lin, walk_lin;
   logic signed [13:0]    nx, ny;
   logic                  n_in_grid, in_disk, walk_rd, hit_now, last_pos, load;
   logic signed [4:0]     rs;
   logic signed [9:0]     dxe, dye;
   logic [9:0]            dsq, rsq;
   logic [15:0]           hits16;

   assign bstat.clearing = (state_ff == B_CLEAR);

   // linear addresses
   assign head_lin = LIN_W'(head.cy) * LIN_W'(GRID_W) + LIN_W'(head.cx);
   assign nx = $signed({2'b00, cmd_ff.cx}) + 14'(dx_ff);
   assign ny = $signed({2'b00, cmd_ff.cy}) + 14'(dy_ff);
   assign walk_lin = LIN_W'(ny[CRD_W-1:0]) * LIN_W'(GRID_W) + LIN_W'(nx[CRD_W-1:0]);
   assign n_in_grid = !nx[13] && !ny[13]
                    && (nx[12:0] < 13'(GRID_W)) && (ny[12:0] < 13'(GRID_H));

   // dilation disk step
   assign rs  = $signed({1'b0, cfg.dil_radius});
   assign dxe = 10'(dx_ff);
   assign dye = 10'(dy_ff);
   assign dsq = 10'(dxe * dxe) + 10'(dye * dye);
   assign rsq = 10'(cfg.dil_radius) * 10'(cfg.dil_radius);
   assign in_disk  = (dsq <= rsq);
   assign walk_rd  = in_disk && n_in_grid;
   assign last_pos = (dx_ff == rs) && (dy_ff == rs);
   assign hit_now  = pend_ff && (16'(rd_data_ff) >= 16'(cfg.min_points));
   assign hits16   = 16'(hits_ff);
   assign load     = (state_ff == B_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      inc_addr_in = inc_addr_ff;
      cmd_in      = cmd_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      pend_in     = 1'b0;
      occ_in      = occ_ff;
      hits_in     = hits_ff;
      pop         = 1'b0;
      rd_addr     = head_lin[ADDR_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = inc_addr_ff;
      wr_data     = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;
      cls_in      = cls_ff;
      hit8_in     = hit8_ff;
      unique case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               pop = 1'b1;
               unique case (head.kind)
                  CMD_START: begin
                     clr_in   = '0;
                     state_in = B_CLEAR;
                  end
                  CMD_POINT: begin
                     inc_addr_in = head_lin[ADDR_W-1:0];
                     state_in    = B_INC;
                  end
                  CMD_QUERY: begin
                     cmd_in = head;
                     occ_in = 1'b0;
                     if (head.outside) begin
                        hits_in  = '0;
                        state_in = B_RESP;
                     end else begin
                        state_in = B_QHIT;
                     end
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end
         B_INC: begin
            wr_en    = 1'b1;
            state_in = B_IDLE;
         end
         B_QHIT: begin
            hits_in  = rd_data_ff;
            dx_in    = -rs;
            dy_in    = -rs;
            state_in = B_WALK;
         end
         B_WALK: begin
            rd_addr = walk_lin[ADDR_W-1:0];
            if (hit_now) begin
               occ_in   = 1'b1;
               state_in = B_RESP;
            end else begin
               pend_in = walk_rd;
               if (last_pos) begin
                  state_in = B_WTAIL;
               end else if (dx_ff == rs) begin
                  dx_in = -rs;
                  dy_in = dy_ff + 1'b1;
               end else begin
                  dx_in = dx_ff + 1'b1;
               end
            end
         end
         B_WTAIL: begin
            if (hit_now) begin
               occ_in = 1'b1;
            end
            state_in = B_RESP;
         end
         B_RESP: begin
            if (load) begin
               if (cmd_ff.outside) begin
                  cls_in = CLS_UNKNOWN;
               end else if (cmd_ff.cleared) begin
                  cls_in = CLS_FREE;
               end else if (occ_ff) begin
                  cls_in = CLS_OCC;
               end else begin
                  cls_in = cfg.init_free ? CLS_FREE : CLS_UNKNOWN;
               end
               hit8_in  = (hits16 > 16'd255) ? 8'hFF : hits16[7:0];
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // result register
   assign rsp_valid_in   = load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_class = cls_ff;
   assign rsp_hit_count  = hit8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_addr_ff <= inc_addr_in;
      cmd_ff      <= cmd_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      occ_ff      <= occ_in;
      hits_ff     <= hits_in;
      cls_ff      <= cls_in;
      hit8_ff     <= hit8_in;
   end

   // hit counter store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR) |-> !pop)
      else $error("command taken during clearing pass");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == B_CLEAR || state_ff == B_INC))
      else $error("counter write outside clear or increment");

   a_inc_after_point: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_INC) |-> $past(pop) && $past(state_ff) == B_IDLE)
      else $error("increment without a popped point");

   a_resp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(cls_ff) && $stable(hit8_ff))
      else $error("held result overwritten");

endmodule

@@ src/point_cloud_occupancy_grid_unit.sv @@
`timescale 1ns / 1ps
// Point words pass the classifier states (idle, multiply, push), then the back end pops
// them and does the counter read-modify-write. The classifier takes one word at a time.
// Query words: the (2*dilation_radius+1)^2 square is walked one cell per cycle on the
// single counter read port, ending early on an obstacle; out-of-grid queries skip it.
// After reset and after every start item the counter store is cleared, one cell per cycle,
// over all GRID_W*GRID_H cells; no word is accepted meanwhile. Reset is synchronous.
module point_cloud_occupancy_grid_unit
   import ocg_pkg::*;
#(
   parameter int GRID_W     = DEF_GRID_W,
   parameter int GRID_H     = DEF_GRID_H,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [23:0] req_point_x,
   input  logic signed [23:0] req_point_y,
   input  logic signed [23:0] req_point_z,
   input  logic signed [23:0] req_origin_x,
   input  logic signed [23:0] req_origin_y,
   input  logic signed [23:0] req_robot_x,
   input  logic signed [23:0] req_robot_y,
   input  logic               req_robot_known,
   input  logic [8:0]         req_query_x,
   input  logic [8:0]         req_query_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_cell_class,
   output logic [7:0]         rsp_hit_count
);

   cfg_type       cfg_ff, cfg_in;
   back_stat_type bstat;
   logic          push, q_full, pop, q_empty;
   cmd_type       push_cmd, head;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CELL_RECIP: cfg_in.cell_recip = csr_data[20:0];
            REG_Z_MIN:      cfg_in.z_min      = $signed(csr_data);
            REG_Z_MAX:      cfg_in.z_max      = $signed(csr_data);
            REG_RANGE:      cfg_in.range_mm   = csr_data[22:0];
            REG_MIN_POINTS: cfg_in.min_points = csr_data[7:0];
            REG_DIL_RADIUS: cfg_in.dil_radius = csr_data[3:0];
            REG_CLR_RADIUS: cfg_in.clr_radius = csr_data[4:0];
            REG_INIT_FREE:  cfg_in.init_free  = csr_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_recip <= 21'd5243;
         cfg_ff.z_min      <= -24'sd150;
         cfg_ff.z_max      <= 24'sd1200;
         cfg_ff.range_mm   <= 23'd120000;
         cfg_ff.min_points <= 8'd1;
         cfg_ff.dil_radius <= 4'd1;
         cfg_ff.clr_radius <= 5'd5;
         cfg_ff.init_free  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ocg_front #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .bstat           (bstat),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_robot_x     (req_robot_x),
      .req_robot_y     (req_robot_y),
      .req_robot_known (req_robot_known),
      .req_query_x     (req_query_x),
      .req_query_y     (req_query_y),
      .push            (push),
      .push_cmd        (push_cmd),
      .q_full          (q_full)
   );

   ocg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty)
   );

   ocg_back #(
      .GRID_W     (GRID_W),
      .GRID_H     (GRID_H),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .bstat          (bstat),
      .head           (head),
      .q_empty        (q_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_class (rsp_cell_class),
      .rsp_hit_count  (rsp_hit_count)
   );

endmodule
